### rtl/core/color_key_sprite_blit_assert.svh
// Assertion macros used by the color key sprite blitter queue.
`ifndef COLOR_KEY_SPRITE_BLIT_ASSERT_SVH
`define COLOR_KEY_SPRITE_BLIT_ASSERT_SVH

`ifndef ASSERT_OFF

// Condition that must hold at every clock edge out of reset.
`define CKB_ASSERT_ALWAYS(name, cond) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
    else $error("%m: invariant violated");

// Antecedent implies consequent in the same cycle.
`define CKB_ASSERT_IMPLIES(name, pre, post) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
    else $error("%m: implication violated");

// Antecedent implies consequent in the next cycle.
`define CKB_ASSERT_NEXT(name, pre, post) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
    else $error("%m: next-cycle implication violated");

`else

`define CKB_ASSERT_ALWAYS(name, cond)
`define CKB_ASSERT_IMPLIES(name, pre, post)
`define CKB_ASSERT_NEXT(name, pre, post)

`endif

`endif

### rtl/core/ckb_pkg.sv
// Shared types and constants of the color key sprite blitter.
`default_nettype none

package ckb_pkg;

  // Largest sprite side accepted before saturation.
  localparam int MAX_DIM_DEF = 2048;

  // Field widths.
  localparam int ACTION_W  = 1;
  localparam int DRAW_W    = 13;
  localparam int CENTER_W  = 11;
  localparam int SIZE_W    = 12;
  localparam int PIX_W     = 32;
  localparam int KEY_W     = 24;
  localparam int DIM_W     = 12;
  localparam int PITCH_W   = 15;
  localparam int ADDR_W    = 25;
  localparam int CFG_DATA_W = 24;
  localparam int CFG_IDX_W = 2;

  // Origin is anchor minus hot spot, one bit wider than the anchor.
  localparam int ORG_W = DRAW_W + 1;
  // Destination position is origin plus a counter, one bit wider again.
  localparam int POS_W = ORG_W + 1;
  localparam int PROD_W = DIM_W + PITCH_W;

  // Input tdata layout, lowest bit first.
  localparam int DRAW_X_LSB   = 0;
  localparam int DRAW_Y_LSB   = DRAW_X_LSB + DRAW_W;
  localparam int CENTER_X_LSB = DRAW_Y_LSB + DRAW_W;
  localparam int CENTER_Y_LSB = CENTER_X_LSB + CENTER_W;
  localparam int SPR_W_LSB    = CENTER_Y_LSB + CENTER_W;
  localparam int SPR_H_LSB    = SPR_W_LSB + SIZE_W;
  localparam int PIXEL_LSB    = SPR_H_LSB + SIZE_W;
  localparam int IN_BITS      = PIXEL_LSB + PIX_W;
  localparam int IN_TDATA_W   = ((IN_BITS + 7) / 8) * 8;

  // Output tdata layout, lowest bit first.
  localparam int ADDR_LSB     = 0;
  localparam int WDATA_LSB    = ADDR_LSB + ADDR_W;
  localparam int OUT_BITS     = WDATA_LSB + PIX_W;
  localparam int OUT_TDATA_W  = ((OUT_BITS + 7) / 8) * 8;

  // Action codes.
  localparam logic [ACTION_W-1:0] ACT_START = 1'b0;
  localparam logic [ACTION_W-1:0] ACT_PIXEL = 1'b1;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_COLOR_KEY   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_DEST_WIDTH  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_DEST_HEIGHT = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_DEST_PITCH  = 2'd3;

  // Configuration reset values.
  localparam logic [KEY_W-1:0]   RST_COLOR_KEY   = 24'd0;
  localparam logic [DIM_W-1:0]   RST_DEST_WIDTH  = 12'd640;
  localparam logic [DIM_W-1:0]   RST_DEST_HEIGHT = 12'd480;
  localparam logic [PITCH_W-1:0] RST_DEST_PITCH  = 15'd2560;

  // Queue between the front and back halves.
  localparam int FIFO_DEPTH = 4;
  localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);
  localparam int FIFO_CNT_W = $clog2(FIFO_DEPTH + 1);

  typedef struct packed {
    logic [KEY_W-1:0]   color_key;
    logic [DIM_W-1:0]   dest_width;
    logic [DIM_W-1:0]   dest_height;
    logic [PITCH_W-1:0] dest_pitch;
  } ckb_cfg_t;

  // One classified item handed from the front to the back.
  typedef struct packed {
    logic               wr;
    logic [DIM_W-1:0]   row;
    logic [DIM_W-1:0]   col;
    logic [PIX_W-1:0]   pixel;
    logic               last;
  } ckb_op_t;

endpackage

`default_nettype wire

### rtl/core/ckb_front.sv
// Front half: sprite state, pixel clipping, key test and last detection.
`default_nettype none

module ckb_front #(
  parameter int MAX_DIM = ckb_pkg::MAX_DIM_DEF
) (
  input  wire                            clk,
  input  wire                            rst_n,
  input  wire                            in_tvalid,
  output logic                           in_tready,
  input  wire  [ckb_pkg::IN_TDATA_W-1:0] in_tdata,
  input  wire  [ckb_pkg::ACTION_W-1:0]   in_tuser,
  input  wire  ckb_pkg::ckb_cfg_t        cfg,
  input  wire                            q_full,
  output logic                           q_push,
  output ckb_pkg::ckb_op_t               q_op
);
  import ckb_pkg::*;

  localparam int CW = $clog2(MAX_DIM);
  localparam int DW = $clog2(MAX_DIM + 1);

  logic signed [ORG_W-1:0] org_col_r, org_col_nxt;
  logic signed [ORG_W-1:0] org_row_r, org_row_nxt;
  logic [DW-1:0]           run_w_r, run_w_nxt;
  logic [DW-1:0]           run_h_r, run_h_nxt;
  logic [CW-1:0]           col_cnt_r, col_cnt_nxt;
  logic [CW-1:0]           row_cnt_r, row_cnt_nxt;
  logic                    busy_r, busy_nxt;

  logic [DRAW_W-1:0]   draw_x, draw_y;
  logic [CENTER_W-1:0] center_x, center_y;
  logic [SIZE_W-1:0]   spr_w, spr_h;
  logic [PIX_W-1:0]    pixel;
  logic                is_pixel;
  logic [DW-1:0]       clamp_w, clamp_h;
  logic [POS_W-1:0]    col_pos, row_pos;
  logic                col_vis, row_vis, key_hit;
  logic [DW-1:0]       col_inc, row_inc;
  logic                col_end, row_end, run_end;
  logic                active;

  assign draw_x   = in_tdata[DRAW_X_LSB +: DRAW_W];
  assign draw_y   = in_tdata[DRAW_Y_LSB +: DRAW_W];
  assign center_x = in_tdata[CENTER_X_LSB +: CENTER_W];
  assign center_y = in_tdata[CENTER_Y_LSB +: CENTER_W];
  assign spr_w    = in_tdata[SPR_W_LSB +: SIZE_W];
  assign spr_h    = in_tdata[SPR_H_LSB +: SIZE_W];
  assign pixel    = in_tdata[PIXEL_LSB +: PIX_W];
  assign is_pixel = (in_tuser == ACT_PIXEL);

  assign in_tready = !q_full;
  assign q_push    = in_tvalid && !q_full;

  // Sizes above the limit saturate to it.
  assign clamp_w = ({1'b0, spr_w} > (SIZE_W + 1)'(MAX_DIM)) ? DW'(MAX_DIM) : DW'(spr_w);
  assign clamp_h = ({1'b0, spr_h} > (SIZE_W + 1)'(MAX_DIM)) ? DW'(MAX_DIM) : DW'(spr_h);

  // Destination position of the current pixel and its clip test.
  assign col_pos = {org_col_r[ORG_W-1], org_col_r} + POS_W'(col_cnt_r);
  assign row_pos = {org_row_r[ORG_W-1], org_row_r} + POS_W'(row_cnt_r);
  assign col_vis = !col_pos[POS_W-1] &&
                   (col_pos[POS_W-2:0] < (POS_W - 1)'(cfg.dest_width));
  assign row_vis = !row_pos[POS_W-1] &&
                   (row_pos[POS_W-2:0] < (POS_W - 1)'(cfg.dest_height));
  assign key_hit = (pixel[KEY_W-1:0] == cfg.color_key);

  assign col_inc = DW'(col_cnt_r) + 1'b1;
  assign row_inc = DW'(row_cnt_r) + 1'b1;
  assign col_end = (col_inc >= run_w_r);
  assign row_end = (row_inc >= run_h_r);
  assign run_end = col_end && row_end;
  assign active  = is_pixel && busy_r;

  always_comb begin
    q_op.wr    = active && col_vis && row_vis && !key_hit;
    q_op.row   = q_op.wr ? row_pos[DIM_W-1:0] : '0;
    q_op.col   = q_op.wr ? col_pos[DIM_W-1:0] : '0;
    q_op.pixel = q_op.wr ? pixel : '0;
    q_op.last  = active && run_end;
  end

  always_comb begin
    org_col_nxt = org_col_r;
    org_row_nxt = org_row_r;
    run_w_nxt   = run_w_r;
    run_h_nxt   = run_h_r;
    col_cnt_nxt = col_cnt_r;
    row_cnt_nxt = row_cnt_r;
    busy_nxt    = busy_r;
    if (q_push) begin
      if (!is_pixel) begin
        org_col_nxt = $signed({draw_x[DRAW_W-1], draw_x}) -
                      $signed({{(ORG_W - CENTER_W){1'b0}}, center_x});
        org_row_nxt = $signed({draw_y[DRAW_W-1], draw_y}) -
                      $signed({{(ORG_W - CENTER_W){1'b0}}, center_y});
        run_w_nxt   = clamp_w;
        run_h_nxt   = clamp_h;
        col_cnt_nxt = '0;
        row_cnt_nxt = '0;
        busy_nxt    = (clamp_w != '0) && (clamp_h != '0);
      end else if (busy_r) begin
        if (run_end) begin
          busy_nxt    = 1'b0;
          col_cnt_nxt = '0;
          row_cnt_nxt = '0;
        end else if (col_end) begin
          col_cnt_nxt = '0;
          row_cnt_nxt = row_cnt_r + 1'b1;
        end else begin
          col_cnt_nxt = col_cnt_r + 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      org_col_r <= '0;
      org_row_r <= '0;
      run_w_r   <= '0;
      run_h_r   <= '0;
      col_cnt_r <= '0;
      row_cnt_r <= '0;
      busy_r    <= 1'b0;
    end else begin
      org_col_r <= org_col_nxt;
      org_row_r <= org_row_nxt;
      run_w_r   <= run_w_nxt;
      run_h_r   <= run_h_nxt;
      col_cnt_r <= col_cnt_nxt;
      row_cnt_r <= row_cnt_nxt;
      busy_r    <= busy_nxt;
    end
  end

endmodule

`default_nettype wire

### rtl/core/ckb_fifo.sv
// Short queue of classified items between the front and back halves.
`default_nettype none

`include "color_key_sprite_blit_assert.svh"

module ckb_fifo (
  input  wire                    clk,
  input  wire                    rst_n,
  input  wire                    push,
  input  wire ckb_pkg::ckb_op_t  push_op,
  output logic                   full,
  input  wire                    pop,
  output ckb_pkg::ckb_op_t       pop_op,
  output logic                   empty
);
  import ckb_pkg::*;

  ckb_op_t               slot_r [FIFO_DEPTH];
  logic [FIFO_PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [FIFO_PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [FIFO_CNT_W-1:0] cnt_r, cnt_nxt;

  assign full   = (cnt_r == FIFO_CNT_W'(FIFO_DEPTH));
  assign empty  = (cnt_r == '0);
  assign pop_op = slot_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = push ? FIFO_PTR_W'(wr_ptr_r + 1'b1) : wr_ptr_r;
    rd_ptr_nxt = pop  ? FIFO_PTR_W'(rd_ptr_r + 1'b1) : rd_ptr_r;
    cnt_nxt    = cnt_r + FIFO_CNT_W'(push) - FIFO_CNT_W'(pop);
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= push_op;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  `CKB_ASSERT_ALWAYS(a_cnt_bound, cnt_r <= FIFO_CNT_W'(FIFO_DEPTH))
  `CKB_ASSERT_IMPLIES(a_pop_nonempty, pop, cnt_r != '0)
  `CKB_ASSERT_IMPLIES(a_push_room, push, !full || pop)
  `CKB_ASSERT_IMPLIES(a_ptr_match, cnt_r == '0 || full, wr_ptr_r == rd_ptr_r)
  `CKB_ASSERT_NEXT(a_cnt_grow, push && !pop, cnt_r == $past(cnt_r) + 1'b1)

endmodule

`default_nettype wire

### rtl/core/ckb_back.sv
// Back half: address multiply, address add and the output register.
`default_nettype none

module ckb_back (
  input  wire                             clk,
  input  wire                             rst_n,
  input  wire  [ckb_pkg::PITCH_W-1:0]     dest_pitch,
  input  wire                             q_empty,
  input  wire  ckb_pkg::ckb_op_t          q_op,
  output logic                            q_pop,
  output logic                            out_tvalid,
  input  wire                             out_tready,
  output logic [ckb_pkg::OUT_TDATA_W-1:0] out_tdata,
  output logic                            out_tuser,
  output logic                            out_tlast
);
  import ckb_pkg::*;

  // Multiply stage.
  logic               s1_v_r;
  logic [PROD_W-1:0]  s1_prod_r;
  logic [DIM_W-1:0]   s1_col_r;
  logic [PIX_W-1:0]   s1_pix_r;
  logic               s1_wr_r;
  logic               s1_last_r;

  // Output register.
  logic               o_v_r;
  logic [ADDR_W-1:0]  o_addr_r;
  logic [PIX_W-1:0]   o_data_r;
  logic               o_we_r;
  logic               o_last_r;

  logic               o_ready, s1_ready;
  logic [PROD_W-1:0]  addr_sum;

  assign o_ready  = !o_v_r || out_tready;
  assign s1_ready = !s1_v_r || o_ready;
  assign q_pop    = !q_empty && s1_ready;
  assign addr_sum = s1_prod_r + PROD_W'({s1_col_r, 2'b00});

  always_ff @(posedge clk) begin
    if (s1_ready) begin
      s1_prod_r <= PROD_W'(q_op.row) * PROD_W'(dest_pitch);
      s1_col_r  <= q_op.col;
      s1_pix_r  <= q_op.pixel;
      s1_wr_r   <= q_op.wr;
      s1_last_r <= q_op.last;
    end
    if (o_ready) begin
      o_addr_r <= s1_wr_r ? addr_sum[ADDR_W-1:0] : '0;
      o_data_r <= s1_wr_r ? s1_pix_r : '0;
      o_we_r   <= s1_wr_r;
      o_last_r <= s1_last_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
      o_v_r  <= 1'b0;
    end else begin
      if (s1_ready) begin
        s1_v_r <= q_pop;
      end
      if (o_ready) begin
        o_v_r <= s1_v_r;
      end
    end
  end

  assign out_tvalid = o_v_r;
  assign out_tuser  = o_we_r;
  assign out_tlast  = o_last_r;
  assign out_tdata  = OUT_TDATA_W'({o_data_r, o_addr_r});

endmodule

`default_nettype wire

### rtl/core/color_key_sprite_blit.sv
// Top level of the color keyed, clipped 32-bit sprite blitter.
//
//  Channel  Direction  Handshake            Payload
//  in_      slave      in_tvalid/tready     tdata: draw_x, draw_y, center_x, center_y,
//                                           sprite_width, sprite_height, pixel;
//                                           tuser: action
//  out_     master     out_tvalid/tready    tdata: dest_addr, write_data;
//                                           tuser: write_enable; tlast: last
//  cfg_     write      cfg_we               cfg_addr index, cfg_wdata value
//
// One transaction is accepted per clock while the queue has room, and each
// input transaction yields exactly one output transaction once the output is free.
// The front half classifies a transaction in the cycle it is accepted; the back
// half registers the row times pitch product in its multiply stage and adds the
// column byte offset ahead of the output register.
// Reset is synchronous and active low; it clears the sprite state, the queue and
// the pipeline valids, and loads the configuration defaults.
// A stalled output fills the back pipeline and then the four-entry queue; only
// when the queue is full does in_tready drop.
`default_nettype none

module color_key_sprite_blit #(
  parameter int MAX_DIM = ckb_pkg::MAX_DIM_DEF
) (
  input  wire                             clk,
  input  wire                             rst_n,

  input  wire                             in_tvalid,
  output logic                            in_tready,
  // From bit 0: draw_x[12:0], draw_y[25:13], center_x[36:26], center_y[47:37],
  // sprite_width[59:48], sprite_height[71:60], pixel[103:72].
  input  wire  [ckb_pkg::IN_TDATA_W-1:0]  in_tdata,
  // From bit 0: action (0 start a sprite, 1 one source pixel).
  input  wire  [ckb_pkg::ACTION_W-1:0]    in_tuser,

  output logic                            out_tvalid,
  input  wire                             out_tready,
  // From bit 0: dest_addr[24:0], write_data[56:25], zero fill above.
  output logic [ckb_pkg::OUT_TDATA_W-1:0] out_tdata,
  // From bit 0: write_enable.
  output logic                            out_tuser,
  output logic                            out_tlast,

  input  wire                             cfg_we,
  input  wire  [ckb_pkg::CFG_IDX_W-1:0]   cfg_addr,
  input  wire  [ckb_pkg::CFG_DATA_W-1:0]  cfg_wdata
);
  import ckb_pkg::*;

  ckb_cfg_t cfg_r, cfg_nxt;
  ckb_op_t  push_op, pop_op;
  logic     q_push, q_pop, q_full, q_empty;

  // Configuration registers. Each write keeps only the low bits its register holds.
  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      case (cfg_addr)
        CFG_COLOR_KEY:   cfg_nxt.color_key   = cfg_wdata[KEY_W-1:0];
        CFG_DEST_WIDTH:  cfg_nxt.dest_width  = cfg_wdata[DIM_W-1:0];
        CFG_DEST_HEIGHT: cfg_nxt.dest_height = cfg_wdata[DIM_W-1:0];
        CFG_DEST_PITCH:  cfg_nxt.dest_pitch  = cfg_wdata[PITCH_W-1:0];
        default:         cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.color_key   <= RST_COLOR_KEY;
      cfg_r.dest_width  <= RST_DEST_WIDTH;
      cfg_r.dest_height <= RST_DEST_HEIGHT;
      cfg_r.dest_pitch  <= RST_DEST_PITCH;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  // The front half owns the sprite counters and decides for every pixel whether
  // it is written, then queues the result.
  ckb_front #(
    .MAX_DIM (MAX_DIM)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .cfg       (cfg_r),
    .q_full    (q_full),
    .q_push    (q_push),
    .q_op      (push_op)
  );

  // The queue lets the front keep taking transactions while the output stalls.
  ckb_fifo u_fifo (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (q_push),
    .push_op (push_op),
    .full    (q_full),
    .pop     (q_pop),
    .pop_op  (pop_op),
    .empty   (q_empty)
  );

  // The back half forms the byte address and drives the output channel.
  ckb_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .dest_pitch (cfg_r.dest_pitch),
    .q_empty    (q_empty),
    .q_op       (pop_op),
    .q_pop      (q_pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

endmodule

`default_nettype wire

### tb/color_key_sprite_blit_tb.sv
// Self-checking testbench of the color keyed, clipped sprite blitter.
`timescale 1ns / 1ps

module color_key_sprite_blit_tb;
  import ckb_pkg::*;

  // One input transaction, unpacked into the fields of the stream.
  typedef struct packed {
    logic [ACTION_W-1:0] action;
    logic [DRAW_W-1:0]   draw_x;
    logic [DRAW_W-1:0]   draw_y;
    logic [CENTER_W-1:0] center_x;
    logic [CENTER_W-1:0] center_y;
    logic [SIZE_W-1:0]   sprite_w;
    logic [SIZE_W-1:0]   sprite_h;
    logic [PIX_W-1:0]    pixel;
  } blit_item_t;

  // One output transaction: the surface write that a pixel causes.
  typedef struct packed {
    logic              wr_en;
    logic [ADDR_W-1:0] addr;
    logic [PIX_W-1:0]  data;
    logic              last;
  } surf_write_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  logic                   in_tvalid = 1'b0;
  logic                   in_tready;
  // From bit 0: draw_x, draw_y, center_x, center_y, sprite_width, sprite_height, pixel.
  logic [IN_TDATA_W-1:0]  in_tdata = '0;
  // From bit 0: action.
  logic [ACTION_W-1:0]    in_tuser = '0;

  logic                   out_tvalid;
  logic                   out_tready = 1'b0;
  // From bit 0: dest_addr, write_data, zero fill above.
  logic [OUT_TDATA_W-1:0] out_tdata;
  // From bit 0: write_enable.
  logic                   out_tuser;
  logic                   out_tlast;

  logic                   cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]   cfg_addr = '0;
  logic [CFG_DATA_W-1:0]  cfg_wdata = '0;

  color_key_sprite_blit u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast),
    .cfg_we     (cfg_we),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata)
  );

  always #1 clk = ~clk;

  // Items waiting to be sent, and the surface writes still owed by the block.
  blit_item_t  blit_items[$];
  surf_write_t owed_writes[$];
  int          error_count = 0;
  int          stim_count;

  // Our copy of the configuration registers.
  logic [KEY_W-1:0] surf_key = RST_COLOR_KEY;
  int surf_w = RST_DEST_WIDTH;
  int surf_h = RST_DEST_HEIGHT;
  int surf_pitch = RST_DEST_PITCH;

  // Our copy of the sprite walk state.
  int org_col = 0;
  int org_row = 0;
  int span_w = 0;
  int span_h = 0;
  int col_idx = 0;
  int row_idx = 0;
  bit drawing = 1'b0;

  // Works out the surface write that one accepted item causes and queues it.
  // A start item latches origin and size; a pixel item walks the raster, is
  // dropped when it falls off the surface or matches the key, and flags the
  // sprite's final pixel no matter whether it is written.
  task automatic compute_write(input blit_item_t it);
    surf_write_t wr;
    int col, row;
    longint byte_addr;
    wr = '0;
    if (it.action == ACT_START) begin
      org_col = int'($signed(it.draw_x)) - int'(it.center_x);
      org_row = int'($signed(it.draw_y)) - int'(it.center_y);
      span_w = (it.sprite_w > MAX_DIM_DEF) ? MAX_DIM_DEF : int'(it.sprite_w);
      span_h = (it.sprite_h > MAX_DIM_DEF) ? MAX_DIM_DEF : int'(it.sprite_h);
      col_idx = 0;
      row_idx = 0;
      drawing = (span_w != 0) && (span_h != 0);
    end else if (drawing) begin
      col = org_col + col_idx;
      row = org_row + row_idx;
      if (col >= 0 && row >= 0 && col < surf_w && row < surf_h &&
          it.pixel[KEY_W-1:0] != surf_key) begin
        byte_addr = longint'(row) * surf_pitch + longint'(col) * 4;
        wr.wr_en = 1'b1;
        wr.addr = byte_addr[ADDR_W-1:0];
        wr.data = it.pixel;
      end
      wr.last = (col_idx + 1 >= span_w) && (row_idx + 1 >= span_h);
      if (wr.last) begin
        drawing = 1'b0;
        col_idx = 0;
        row_idx = 0;
      end else if (col_idx + 1 >= span_w) begin
        col_idx = 0;
        row_idx++;
      end else begin
        col_idx++;
      end
    end
    owed_writes.push_back(wr);
  endtask

  // Idle stretch length: mostly none, often short, now and then long.
  function automatic int idle_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(4, 20);
  endfunction

  // Input driver. Each side alternates between calm stretches with no idling
  // and busy stretches with random gaps, so gaps land on every pipeline phase.
  blit_item_t send_item;
  int send_gap = 0;
  int send_mode_left = 0;
  bit send_calm = 1'b0;

  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else if (!in_tvalid || in_tready) begin
      // The transaction on the bus, if any, was taken at this edge.
      if (in_tvalid) compute_write(send_item);
      if (send_gap > 0 || blit_items.size() == 0) begin
        if (send_gap > 0) send_gap--;
        in_tvalid <= 1'b0;
      end else begin
        send_item = blit_items.pop_front();
        in_tvalid <= 1'b1;
        in_tuser <= send_item.action;
        in_tdata <= {send_item.pixel, send_item.sprite_h, send_item.sprite_w,
                     send_item.center_y, send_item.center_x,
                     send_item.draw_y, send_item.draw_x};
        if (send_mode_left == 0) begin
          send_calm = ($urandom_range(0, 2) == 0);
          send_mode_left = $urandom_range(20, 200);
        end else begin
          send_mode_left--;
        end
        send_gap = send_calm ? 0 : idle_len();
      end
    end
  end

  // Output monitor and back-pressure. Every taken write is compared with the
  // oldest one owed; fields are shown as write enable/address/data/last.
  surf_write_t got_wr;
  surf_write_t want_wr;
  int stall_left = 0;
  int recv_mode_left = 0;
  bit recv_calm = 1'b0;

  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      if (out_tvalid && out_tready) begin
        got_wr.wr_en = out_tuser;
        got_wr.addr = out_tdata[ADDR_LSB +: ADDR_W];
        got_wr.data = out_tdata[WDATA_LSB +: PIX_W];
        got_wr.last = out_tlast;
        if (owed_writes.size() == 0) begin
          error_count++;
          $display("%0t: unexpected write: expected none, actual %0b/%h/%h/%0b",
                   $time, got_wr.wr_en, got_wr.addr, got_wr.data, got_wr.last);
        end else begin
          want_wr = owed_writes.pop_front();
          if (got_wr !== want_wr) begin
            error_count++;
            $display("%0t: write mismatch: expected %0b/%h/%h/%0b, actual %0b/%h/%h/%0b",
                     $time, want_wr.wr_en, want_wr.addr, want_wr.data, want_wr.last,
                     got_wr.wr_en, got_wr.addr, got_wr.data, got_wr.last);
          end
        end
      end
      if (stall_left > 0) begin
        stall_left--;
        out_tready <= 1'b0;
      end else begin
        out_tready <= 1'b1;
        if (recv_mode_left == 0) begin
          recv_calm = ($urandom_range(0, 2) == 0);
          recv_mode_left = $urandom_range(20, 200);
        end else begin
          recv_mode_left--;
        end
        stall_left = recv_calm ? 0 : idle_len();
      end
    end
  end

  task automatic push_start(input logic [DRAW_W-1:0] dx, input logic [DRAW_W-1:0] dy,
                            input int cx, input int cy, input int w, input int h);
    blit_item_t it;
    it.action = ACT_START;
    it.draw_x = dx;
    it.draw_y = dy;
    it.center_x = cx[CENTER_W-1:0];
    it.center_y = cy[CENTER_W-1:0];
    it.sprite_w = w[SIZE_W-1:0];
    it.sprite_h = h[SIZE_W-1:0];
    // The pixel is ignored on a start, so it may as well be noise.
    it.pixel = $urandom;
    blit_items.push_back(it);
  endtask

  task automatic push_pixel(input logic [PIX_W-1:0] pix);
    blit_item_t it;
    logic [127:0] noise;
    noise = {$urandom, $urandom, $urandom, $urandom};
    it = noise[$bits(blit_item_t)-1:0];
    it.action = ACT_PIXEL;
    it.pixel = pix;
    blit_items.push_back(it);
  endtask

  // A source pixel, often one that carries the key in its color bits.
  function automatic logic [PIX_W-1:0] pick_pixel();
    logic [PIX_W-1:0] pix;
    pix = $urandom;
    if ($urandom_range(0, 99) < 30) pix[KEY_W-1:0] = surf_key;
    return pix;
  endfunction

  // Queues one sprite: mostly well formed and placed around the surface so
  // that clipping happens on every edge, sometimes cut short by a new start,
  // sometimes of zero size, sometimes trailed by pixels that arrive idle.
  task automatic queue_random_sprite();
    int w, h, cx, cy, ox, oy, npix;
    logic [DRAW_W-1:0] dx, dy;
    if ($urandom_range(0, 99) < 12) begin
      dx = DRAW_W'($urandom);
      dy = DRAW_W'($urandom);
      cx = $urandom_range(0, 2047);
      cy = $urandom_range(0, 2047);
    end else begin
      cx = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 2047) : $urandom_range(0, 15);
      cy = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 2047) : $urandom_range(0, 15);
      ox = $urandom_range(0, surf_w + 16) - 8;
      oy = $urandom_range(0, surf_h + 16) - 8;
      dx = DRAW_W'(ox + cx);
      dy = DRAW_W'(oy + cy);
    end
    w = ($urandom_range(0, 99) < 70) ? $urandom_range(1, 6) : $urandom_range(1, 20);
    h = ($urandom_range(0, 99) < 70) ? $urandom_range(1, 6) : $urandom_range(1, 20);
    if ($urandom_range(0, 19) == 0) begin
      if ($urandom_range(0, 1)) w = 0;
      else h = 0;
    end
    push_start(dx, dy, cx, cy, w, h);
    npix = w * h;
    if (npix > 0 && $urandom_range(0, 9) == 0) npix = $urandom_range(0, npix - 1);
    for (int i = 0; i < npix; i++) push_pixel(pick_pixel());
    stim_count += npix + 1;
    if ($urandom_range(0, 99) < 8) begin
      repeat ($urandom_range(1, 3)) push_pixel($urandom);
    end
  endtask

  // Returns once everything queued has been sent and every owed write has come
  // back, and then waits on so the pipeline is empty.
  task automatic wait_drained();
    do @(negedge clk); while (blit_items.size() != 0 || in_tvalid || owed_writes.size() != 0);
    repeat (6) @(negedge clk);
  endtask

  // Register writes happen only while the block is idle, so our copy is
  // updated at the same time.
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int value);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_addr <= idx;
    cfg_wdata <= value[CFG_DATA_W-1:0];
    case (idx)
      CFG_COLOR_KEY:   surf_key = value[KEY_W-1:0];
      CFG_DEST_WIDTH:  surf_w = value & 32'hfff;
      CFG_DEST_HEIGHT: surf_h = value & 32'hfff;
      CFG_DEST_PITCH:  surf_pitch = value & 32'h7fff;
      default: ;
    endcase
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic set_surface(input int key, input int w, input int h, input int pitch);
    write_reg(CFG_COLOR_KEY, key);
    write_reg(CFG_DEST_WIDTH, w);
    write_reg(CFG_DEST_HEIGHT, h);
    write_reg(CFG_DEST_PITCH, pitch);
  endtask

  initial begin
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    // Directed part, on the reset configuration (key 0, 640 by 480).
    // A pixel with no sprite in progress gives an empty transaction.
    push_pixel(32'hffffffff);
    // A small sprite fully on the surface; two pixels are keyed even though
    // their top byte is set, the sixth ends the draw and a seventh follows it.
    push_start(13'd10, 13'd5, 0, 0, 3, 2);
    push_pixel(32'h12345678);
    push_pixel(32'hff000000);
    push_pixel(32'h00000001);
    push_pixel(32'h80ffffff);
    push_pixel(32'h7f000000);
    push_pixel(32'hdeadbeef);
    push_pixel(32'h00000000);
    // A zero-size start begins nothing.
    push_start(13'd20, 13'd20, 0, 0, 0, 5);
    push_pixel(32'h00abcdef);
    // Most negative anchor minus the largest hot spot, with oversize sides;
    // it is abandoned by the next start while still in progress.
    push_start(13'h1000, 13'h1000, 2047, 2047, 4095, 4095);
    push_pixel(32'h11111111);
    push_pixel(32'h22222222);
    // Largest anchor: everything falls off the right and bottom.
    push_start(13'h0fff, 13'h0fff, 0, 0, 2, 1);
    push_pixel(32'h33333333);
    push_pixel(32'h44444444);
    // Straddles the bottom right corner of the surface.
    push_start(13'd639, 13'd479, 1, 1, 3, 3);
    for (int i = 0; i < 9; i++) push_pixel(32'h01000000 * i + 32'h00102030);
    wait_drained();

    // Largest surface and pitch, so sprites near the far corner reach the
    // top addresses.
    set_surface($urandom_range(0, 24'hffffff), 2048, 2048, 16384);
    stim_count = 0;
    while (stim_count < 200) queue_random_sprite();
    wait_drained();

    // Smallest surface and pitch, with an all-ones key.
    set_surface(24'hffffff, 1, 1, 4);
    stim_count = 0;
    while (stim_count < 200) queue_random_sprite();
    wait_drained();

    // A zero key on a random surface, then fully random settings.
    for (int phase = 0; phase < 4; phase++) begin
      set_surface(phase == 0 ? 0 : $urandom_range(0, 24'hffffff),
                  $urandom_range(1, 2048), $urandom_range(1, 2048),
                  $urandom_range(4, 16384));
      stim_count = 0;
      while (stim_count < 200) queue_random_sprite();
      wait_drained();
    end

    repeat (10) @(posedge clk);
    if (error_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  // Watchdog for a hung handshake.
  initial begin
    #2000000;
    $display("Verification failed");
    $finish;
  end

endmodule
